[rtl/rgsc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgsc_pkg: shared types and constants of the gradient color block
// Holds the per-cell item record, the sequencer states and the constant
// divide by ten that the span reduction uses.
// ---------------------------------------------------------------------------
package rgsc_pkg;

    // channel and reduced-span widths
    localparam int unsigned CHAN_W       = 8;
    localparam int unsigned NUM_CHAN     = 3;
    localparam int unsigned RSPAN_W      = 6;
    localparam int unsigned MOVE_W       = CHAN_W + RSPAN_W;
    localparam int unsigned COLOR_W      = CHAN_W * NUM_CHAN;
    localparam int unsigned DIV_CELLS    = CHAN_W;

    // span reduction
    localparam int unsigned REDUCE_LIMIT = 50;
    localparam int unsigned WIDE_W       = 16;
    localparam logic [31:0] RECIP_10     = 32'd52429;
    localparam int unsigned RECIP_SHIFT  = 19;

    // reduction sequencer states
    typedef enum logic {
        RS_IDLE,
        RS_REDUCE
    } t_red_state;

    // one channel as it travels down the divider chain
    typedef struct packed {
        logic [CHAN_W-1:0]  base;
        logic               dn;
        logic [CHAN_W-1:0]  diff;
        logic [RSPAN_W-1:0] rem;
        logic [CHAN_W-1:0]  dvd;
        logic [CHAN_W-1:0]  quo;
    } t_chan;

    // one item in a cell of the chain
    typedef struct packed {
        logic                       vld;
        logic [RSPAN_W-1:0]         dsr;
        logic [RSPAN_W-1:0]         stp;
        t_chan [NUM_CHAN-1:0]       ch;
    } t_cell;

    // floor(x / 10), exact for every 16-bit x
    function automatic logic [WIDE_W-1:0] div10(input logic [WIDE_W-1:0] x);
        logic [31:0] p;
        p = 32'(x) * RECIP_10;
        return WIDE_W'(p >> RECIP_SHIFT);
    endfunction

endpackage
`default_nettype wire

[rtl/rgsc_div_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgsc_div_cell: one restoring division step
// Produces one quotient bit of |start - end| / reduced span for all three channels
// and hands the item to the next cell on the following clock.
// ---------------------------------------------------------------------------
module rgsc_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  rgsc_pkg::t_cell     i_cell,
    output rgsc_pkg::t_cell     o_cell
);

    rgsc_pkg::t_cell r_cell;
    rgsc_pkg::t_cell n_cell;

    // shift in one dividend bit, subtract the divisor when it fits
    always_comb begin
        logic [rgsc_pkg::RSPAN_W:0] trial;
        logic [rgsc_pkg::RSPAN_W:0] dsr_x;
        logic                       ge;
        n_cell = i_cell;
        dsr_x  = {1'b0, i_cell.dsr};
        for (int c = 0; c < rgsc_pkg::NUM_CHAN; c++) begin
            trial = {i_cell.ch[c].rem, i_cell.ch[c].dvd[rgsc_pkg::CHAN_W-1]};
            ge    = (trial >= dsr_x);
            n_cell.ch[c].rem = ge ? rgsc_pkg::RSPAN_W'(trial - dsr_x)
                                  : trial[rgsc_pkg::RSPAN_W-1:0];
            n_cell.ch[c].dvd = {i_cell.ch[c].dvd[rgsc_pkg::CHAN_W-2:0], 1'b0};
            n_cell.ch[c].quo = {i_cell.ch[c].quo[rgsc_pkg::CHAN_W-2:0], ge};
        end
    end

    // cell register, only the valid bit is cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

[rtl/rgsc_reduce.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgsc_reduce: input capture and span reduction
// Saturates step to span, divides both by ten while span exceeds the limit,
// then forms the channel differences and launches the item into the chain.
// ---------------------------------------------------------------------------
module rgsc_reduce #(
    parameter int unsigned SPAN_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rgsc_pkg::COLOR_W-1:0]  i_start_color,
    input  wire logic [rgsc_pkg::COLOR_W-1:0]  i_end_color,
    input  wire logic [SPAN_BITS-1:0]          i_span,
    input  wire logic [SPAN_BITS-1:0]          i_step,
    output rgsc_pkg::t_cell                    o_cell,
    output logic                               o_busy
);

    rgsc_pkg::t_red_state              r_state, n_state;
    logic [SPAN_BITS-1:0]              r_span, n_span;
    logic [SPAN_BITS-1:0]              r_step, n_step;
    logic [rgsc_pkg::COLOR_W-1:0]      r_c0, n_c0;
    logic [rgsc_pkg::COLOR_W-1:0]      r_c1, n_c1;
    rgsc_pkg::t_cell                   r_cell, n_cell;

    // next state, reduction and launch
    always_comb begin
        logic [rgsc_pkg::CHAN_W-1:0] a;
        logic [rgsc_pkg::CHAN_W-1:0] b;
        a          = '0;
        b          = '0;
        n_state    = r_state;
        n_span     = r_span;
        n_step     = r_step;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_cell     = r_cell;
        n_cell.vld = 1'b0;
        unique case (r_state)
            rgsc_pkg::RS_IDLE: begin
                if (i_start) begin
                    n_span  = i_span;
                    n_step  = (i_step > i_span) ? i_span : i_step;
                    n_c0    = i_start_color;
                    n_c1    = i_end_color;
                    n_state = rgsc_pkg::RS_REDUCE;
                end
            end
            rgsc_pkg::RS_REDUCE: begin
                if (r_span > SPAN_BITS'(rgsc_pkg::REDUCE_LIMIT)) begin
                    n_span = SPAN_BITS'(rgsc_pkg::div10(rgsc_pkg::WIDE_W'(r_span)));
                    n_step = SPAN_BITS'(rgsc_pkg::div10(rgsc_pkg::WIDE_W'(r_step)));
                end else begin
                    n_cell.vld = 1'b1;
                    n_cell.dsr = rgsc_pkg::RSPAN_W'(r_span);
                    n_cell.stp = rgsc_pkg::RSPAN_W'(r_step);
                    for (int c = 0; c < rgsc_pkg::NUM_CHAN; c++) begin
                        a = r_c0[c*rgsc_pkg::CHAN_W +: rgsc_pkg::CHAN_W];
                        b = r_c1[c*rgsc_pkg::CHAN_W +: rgsc_pkg::CHAN_W];
                        n_cell.ch[c].base = a;
                        n_cell.ch[c].dn   = (a > b);
                        n_cell.ch[c].diff = (a > b) ? (a - b) : (b - a);
                        n_cell.ch[c].rem  = '0;
                        n_cell.ch[c].dvd  = (a > b) ? (a - b) : (b - a);
                        n_cell.ch[c].quo  = '0;
                    end
                    n_state = rgsc_pkg::RS_IDLE;
                end
            end
            default: begin
                n_state = rgsc_pkg::RS_IDLE;
            end
        endcase
    end

    // state and launch valid are reset, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rgsc_pkg::RS_IDLE;
            r_cell.vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_span  <= n_span;
            r_step  <= n_step;
            r_c0    <= n_c0;
            r_c1    <= n_c1;
            r_cell  <= n_cell;
        end
    end

    assign o_cell = r_cell;
    assign o_busy = (r_state != rgsc_pkg::RS_IDLE);

endmodule
`default_nettype wire

[rtl/rgb_gradient_step_color.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_gradient_step_color: color of one pixel on a two-color gradient line
// Reduces span and step, divides each channel difference in a chain of
// restoring division cells and moves the start color toward the end color.
// ---------------------------------------------------------------------------
// One item at a time: an item is taken when start is high and busy is low,
// and its color appears on o_pixel_color with o_valid high for exactly one
// cycle, which the receiver cannot stall. From the accepting edge an item
// passes through the span reduction loop, which divides by ten until the
// span is 50 or below (0 to 2 passes at 12 span bits, up to 4 at 16), the
// eight-cell division chain and the result register to the strobe. busy
// falls in the cycle the strobe is shown, so the next item can be taken
// while the previous result is on the outputs.
// ---------------------------------------------------------------------------
module rgb_gradient_step_color #(
    parameter int unsigned SPAN_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rgsc_pkg::COLOR_W-1:0]  i_start_color,
    input  wire logic [rgsc_pkg::COLOR_W-1:0]  i_end_color,
    input  wire logic [SPAN_BITS-1:0]          i_span,
    input  wire logic [SPAN_BITS-1:0]          i_step,
    output logic [rgsc_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                               o_valid
);

    rgsc_pkg::t_cell                 w_stage [0:rgsc_pkg::DIV_CELLS];
    logic                            w_red_busy;
    logic                            w_chain_busy;
    logic [rgsc_pkg::COLOR_W-1:0]    r_pix, n_pix;
    logic                            r_vld;

    // capture and span reduction
    rgsc_reduce #(
        .SPAN_BITS (SPAN_BITS)
    ) u_reduce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start & ~busy),
        .i_start_color (i_start_color),
        .i_end_color   (i_end_color),
        .i_span        (i_span),
        .i_step        (i_step),
        .o_cell        (w_stage[0]),
        .o_busy        (w_red_busy)
    );

    // division chain, one quotient bit per cell
    for (genvar g = 0; g < rgsc_pkg::DIV_CELLS; g++) begin : g_cell
        rgsc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_stage[g]),
            .o_cell  (w_stage[g+1])
        );
    end

    // any item still in the chain keeps the block busy
    always_comb begin
        w_chain_busy = 1'b0;
        for (int k = 0; k <= rgsc_pkg::DIV_CELLS; k++) begin
            w_chain_busy = w_chain_busy | w_stage[k].vld;
        end
    end

    assign busy = w_red_busy | w_chain_busy;

    // increment times step, clamped to the difference, applied to start
    always_comb begin
        rgsc_pkg::t_cell              last;
        logic [rgsc_pkg::CHAN_W-1:0]  inc;
        logic [rgsc_pkg::MOVE_W-1:0]  move;
        logic [rgsc_pkg::CHAN_W-1:0]  mv;
        last = w_stage[rgsc_pkg::DIV_CELLS];
        for (int c = 0; c < rgsc_pkg::NUM_CHAN; c++) begin
            inc  = (last.dsr == '0) ? '0 : last.ch[c].quo;
            move = rgsc_pkg::MOVE_W'(inc) * rgsc_pkg::MOVE_W'(last.stp);
            mv   = (move > rgsc_pkg::MOVE_W'(last.ch[c].diff))
                   ? last.ch[c].diff : move[rgsc_pkg::CHAN_W-1:0];
            n_pix[c*rgsc_pkg::CHAN_W +: rgsc_pkg::CHAN_W] =
                last.ch[c].dn ? (last.ch[c].base - mv) : (last.ch[c].base + mv);
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_stage[rgsc_pkg::DIV_CELLS].vld;
            r_pix <= n_pix;
        end
    end

    assign o_pixel_color = r_pix;
    assign o_valid       = r_vld;

endmodule
`default_nettype wire
